>>> design/cot_pkg.sv
// Shared types and constants of the clock offset tracker.
// Holds the operation and result codes, the controller states and the
// command and status structs between controller and datapath. No dependencies.
package cot_pkg;

	localparam int SAMPLE_DEPTH = 8;
	localparam int IDX_W = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(SAMPLE_DEPTH + 1);

	localparam int TIME_W  = 48;
	localparam int OFS_W   = 49;
	localparam int RTT_W   = 16;
	localparam int DELTA_W = 24;
	localparam int RATE_W  = 10;
	localparam int CFG_W   = 16;

	// Slew step: floor(rate * delta / 1e6) through a reciprocal multiply.
	localparam int PROD_W      = RATE_W + DELTA_W;
	localparam int RECIP_W     = 31;
	localparam int RECIP_SHIFT = 50;
	localparam logic [RECIP_W-1:0] RECIP = 31'd1125899906;  // floor(2^50 / 1e6)
	localparam int Q_W   = 15;
	localparam int REM_W = 21;
	localparam logic [REM_W-1:0] USEC_PER_S = 21'd1000000;

	localparam logic [CFG_W-1:0]  MAX_RTT_RST = 16'd1000;
	localparam logic [RATE_W-1:0] SLEW_RST    = 10'd25;

	typedef enum logic [0:0] {
		CFG_MAX_RTT = 1'b0,
		CFG_SLEW    = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		OP_PING = 2'd0,
		OP_ECHO = 2'd1,
		OP_TICK = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_ACCEPTED = 2'd1,
		STAT_DROPPED  = 2'd2,
		STAT_NO_PING  = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PING,
		ST_ECHO_RTT,
		ST_ECHO_CHK,
		ST_ECHO_SUM,
		ST_PUSH,
		ST_WALK,
		ST_SET,
		ST_TICK_MUL,
		ST_TICK_RECIP,
		ST_TICK_REM,
		ST_TICK_CORR,
		ST_TICK_APPLY,
		ST_DONE
	} ctl_state_t;

	typedef struct packed {
		logic    latch;
		logic    ping;
		logic    rtt_calc;
		logic    rtt_report;
		logic    ofs_sum;
		logic    push;
		logic    walk;
		logic    set_target;
		logic    tick_mul;
		logic    tick_recip;
		logic    tick_rem;
		logic    tick_corr;
		logic    tick_apply;
		logic    load_out;
		status_t status;
	} dp_cmd_t;

	typedef struct packed {
		logic no_ping;
		logic too_long;
		logic walk_last;
		logic synced;
	} dp_stat_t;

endpackage

>>> design/clock_offset_tracker.sv
// Clock offset tracker built from cot_ctrl and cot_dpath, with shared types in cot_pkg.
// Each transaction steps through the controller states to ST_DONE, where its result is loaded;
// an echo visits every kept sample, and a tick before the first sync, a dropped echo and an
// echo with no pending ping skip to ST_DONE. One transaction at a time: the next is accepted
// once the result is loaded, and input is taken while a result waits for m_tready.
// Asynchronous active-low reset clears all tracker state and restores both registers.
module clock_offset_tracker (
	input  logic         clk,
	input  logic         arst_n,
	// Configuration writes: index 0 round-trip limit in ms, index 1 slew rate in ms per second.
	input  logic         cfg_we,
	input  logic [0:0]   cfg_index,
	input  logic [15:0]  cfg_data,
	// Input stream.
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [119:0] s_tdata,  // local_time_ms[47:0], server_stamp_ms[95:48],
	                               // tick_delta_us[119:96]
	input  logic [1:0]   s_tuser,  // operation[1:0]
	// Result stream.
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [119:0] m_tdata,  // rtt_ms[15:0], target_offset_ms[64:16],
	                               // applied_offset_ms[113:65], synced[114], zero[119:115]
	output logic [1:0]   m_tuser   // status[1:0]
);
	import cot_pkg::*;

	dp_cmd_t                 cmd;
	dp_stat_t                stat;
	status_t                 out_status;
	logic [RTT_W-1:0]        out_rtt_ms;
	logic signed [OFS_W-1:0] out_target_ms;
	logic signed [OFS_W-1:0] out_applied_ms;
	logic                    out_synced;

	// The controller walks each transaction through its steps: a ping stores
	// the send time, an echo checks the pending ping, measures the round trip,
	// forms the offset, pushes it into the ring of kept samples and then visits
	// every kept sample from the oldest to find the least round trip. A tick
	// multiplies rate by elapsed time, divides by one million through a
	// reciprocal multiply with a single correction, and slews the applied offset.
	cot_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.op       (op_t'(s_tuser)),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	cot_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_idx_t'(cfg_index)),
		.cfg_data        (cfg_data),
		.local_time_ms   (s_tdata[47:0]),
		.server_stamp_ms (s_tdata[95:48]),
		.tick_delta_us   (s_tdata[119:96]),
		.cmd             (cmd),
		.stat            (stat),
		.out_status      (out_status),
		.out_rtt_ms      (out_rtt_ms),
		.out_target_ms   (out_target_ms),
		.out_applied_ms  (out_applied_ms),
		.out_synced      (out_synced)
	);

	// Result fields packed from the lowest bit up, padded to whole bytes.
	assign m_tdata = {5'b00000, out_synced, out_applied_ms, out_target_ms, out_rtt_ms};
	assign m_tuser = out_status;

endmodule

>>> design/cot_ctrl.sv
// Controller of the clock offset tracker: sequences one transaction at a time.
// Depends on cot_pkg; drives the datapath through dp_cmd_t and reads dp_stat_t.
module cot_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  cot_pkg::op_t      op,
	output logic              m_tvalid,
	input  logic              m_tready,
	input  cot_pkg::dp_stat_t stat,
	output cot_pkg::dp_cmd_t  cmd
);
	import cot_pkg::*;

	ctl_state_t state_q, state_d;
	status_t    status_q, status_d;
	logic       m_tvalid_q, m_tvalid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			status_q   <= STAT_OK;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			status_q   <= status_d;
			m_tvalid_q <= m_tvalid_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		status_d   = status_q;
		m_tvalid_d = m_tvalid_q;
		cmd        = '0;
		cmd.status = status_q;
		s_tready   = 1'b0;
		if (m_tvalid_q && m_tready) begin
			m_tvalid_d = 1'b0;
		end
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.latch = 1'b1;
					status_d  = STAT_OK;
					unique case (op)
						OP_PING: state_d = ST_PING;
						OP_ECHO: state_d = ST_ECHO_RTT;
						OP_TICK: state_d = ST_TICK_MUL;
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_PING: begin
				cmd.ping = 1'b1;
				state_d  = ST_DONE;
			end
			ST_ECHO_RTT: begin
				if (stat.no_ping) begin
					status_d = STAT_NO_PING;
					state_d  = ST_DONE;
				end else begin
					cmd.rtt_calc = 1'b1;
					state_d      = ST_ECHO_CHK;
				end
			end
			ST_ECHO_CHK: begin
				cmd.rtt_report = 1'b1;
				if (stat.too_long) begin
					status_d = STAT_DROPPED;
					state_d  = ST_DONE;
				end else begin
					cmd.ofs_sum = 1'b1;
					state_d     = ST_ECHO_SUM;
				end
			end
			ST_ECHO_SUM: begin
				cmd.push = 1'b1;
				state_d  = ST_PUSH;
			end
			ST_PUSH: begin
				cmd.walk = 1'b1;
				state_d  = stat.walk_last ? ST_SET : ST_WALK;
			end
			ST_WALK: begin
				cmd.walk = 1'b1;
				if (stat.walk_last) begin
					state_d = ST_SET;
				end
			end
			ST_SET: begin
				cmd.set_target = 1'b1;
				status_d       = STAT_ACCEPTED;
				state_d        = ST_DONE;
			end
			ST_TICK_MUL: begin
				if (!stat.synced) begin
					state_d = ST_DONE;
				end else begin
					cmd.tick_mul = 1'b1;
					state_d      = ST_TICK_RECIP;
				end
			end
			ST_TICK_RECIP: begin
				cmd.tick_recip = 1'b1;
				state_d        = ST_TICK_REM;
			end
			ST_TICK_REM: begin
				cmd.tick_rem = 1'b1;
				state_d      = ST_TICK_CORR;
			end
			ST_TICK_CORR: begin
				cmd.tick_corr = 1'b1;
				state_d       = ST_TICK_APPLY;
			end
			ST_TICK_APPLY: begin
				cmd.tick_apply = 1'b1;
				state_d        = ST_DONE;
			end
			ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					cmd.load_out = 1'b1;
					m_tvalid_d   = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign m_tvalid = m_tvalid_q;

endmodule

>>> design/cot_dpath.sv
// Datapath of the clock offset tracker: time arithmetic, sample store,
// minimum-rtt walk, slew step and the result register. Depends on cot_pkg.
module cot_dpath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  cot_pkg::cfg_idx_t            cfg_index,
	input  logic [cot_pkg::CFG_W-1:0]    cfg_data,
	input  logic [cot_pkg::TIME_W-1:0]   local_time_ms,
	input  logic [cot_pkg::TIME_W-1:0]   server_stamp_ms,
	input  logic [cot_pkg::DELTA_W-1:0]  tick_delta_us,
	input  cot_pkg::dp_cmd_t             cmd,
	output cot_pkg::dp_stat_t            stat,
	output cot_pkg::status_t             out_status,
	output logic [cot_pkg::RTT_W-1:0]    out_rtt_ms,
	output logic signed [cot_pkg::OFS_W-1:0] out_target_ms,
	output logic signed [cot_pkg::OFS_W-1:0] out_applied_ms,
	output logic                         out_synced
);
	import cot_pkg::*;

	localparam logic [IDX_W:0] DEPTH_L = (IDX_W + 1)'(SAMPLE_DEPTH);
	localparam logic signed [OFS_W:0] OFS_MAX = {2'b00, {(OFS_W - 1){1'b1}}};
	localparam logic signed [OFS_W:0] OFS_MIN = {2'b11, {(OFS_W - 1){1'b0}}};

	function automatic logic [IDX_W-1:0] inc_idx(input logic [IDX_W-1:0] k);
		inc_idx = (k == IDX_W'(SAMPLE_DEPTH - 1)) ? '0 : k + 1'b1;
	endfunction

	// Configuration.
	logic [CFG_W-1:0]  max_rtt_q;
	logic [RATE_W-1:0] slew_q;

	// Latched input fields.
	logic [TIME_W-1:0]  now_q, stamp_q;
	logic [DELTA_W-1:0] delta_q;

	// Tracker state.
	logic [TIME_W-1:0]       pend_q;
	logic [CNT_W-1:0]        count_q;
	logic [IDX_W-1:0]        oldest_q;
	logic signed [OFS_W-1:0] target_q, applied_q;
	logic                    sync_q;
	logic signed [OFS_W-1:0] ofs_mem_q [SAMPLE_DEPTH];
	logic [RTT_W-1:0]        rtt_mem_q [SAMPLE_DEPTH];

	// Echo working registers.
	logic [TIME_W-1:0] rtt_q;
	logic [RTT_W-1:0]  rtt_out_q;
	logic [OFS_W-1:0]  sum_q;

	// Walk registers.
	logic [IDX_W-1:0]        walk_k_q;
	logic [CNT_W-1:0]        walk_i_q;
	logic signed [OFS_W-1:0] best_ofs_q;
	logic [RTT_W-1:0]        best_rtt_q;

	// Tick working registers.
	logic [PROD_W-1:0]       prod_q;
	logic [Q_W-1:0]          q0_q, step_q;
	logic [REM_W-1:0]        rem_q;
	logic signed [OFS_W:0]   diff_q;
	logic [OFS_W:0]          mag_q;

	// Output register payload.
	status_t                 out_status_q;
	logic [RTT_W-1:0]        out_rtt_q;
	logic signed [OFS_W-1:0] out_target_q, out_applied_q;
	logic                    out_synced_q;

	// Combinational terms.
	logic [IDX_W:0]              slot_sum;
	logic [IDX_W-1:0]            slot;
	logic [IDX_W-1:0]            oldest_nxt;
	logic signed [OFS_W:0]       ofs_raw;
	logic signed [OFS_W-1:0]     ofs_sat;
	logic [PROD_W+RECIP_W-1:0]   recip_prod;
	logic [PROD_W:0]             q_times;
	logic [Q_W-1:0]              q_fix;
	logic                        take;

	assign slot_sum   = {1'b0, oldest_q} + (IDX_W + 1)'(count_q);
	assign slot       = (slot_sum >= DEPTH_L) ? IDX_W'(slot_sum - DEPTH_L) : IDX_W'(slot_sum);
	assign oldest_nxt = (count_q == CNT_W'(SAMPLE_DEPTH)) ? inc_idx(oldest_q) : oldest_q;

	assign ofs_raw = $signed({1'b0, sum_q}) - $signed({2'b00, now_q});
	always_comb begin
		if (ofs_raw > OFS_MAX) begin
			ofs_sat = OFS_MAX[OFS_W-1:0];
		end else if (ofs_raw < OFS_MIN) begin
			ofs_sat = OFS_MIN[OFS_W-1:0];
		end else begin
			ofs_sat = ofs_raw[OFS_W-1:0];
		end
	end

	assign recip_prod = {{RECIP_W{1'b0}}, prod_q} * {{PROD_W{1'b0}}, RECIP};
	assign q_times    = (PROD_W + 1)'(q0_q) * (PROD_W + 1)'(USEC_PER_S);
	assign q_fix      = q0_q + Q_W'(rem_q >= USEC_PER_S);

	assign take = (walk_i_q == '0) || (rtt_mem_q[walk_k_q] < best_rtt_q);

	assign stat.no_ping   = (pend_q == '0) || (now_q < pend_q);
	assign stat.too_long  = rtt_q > TIME_W'(max_rtt_q);
	assign stat.walk_last = walk_i_q == (count_q - 1'b1);
	assign stat.synced    = sync_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_rtt_q <= MAX_RTT_RST;
			slew_q    <= SLEW_RST;
			pend_q    <= '0;
			count_q   <= '0;
			oldest_q  <= '0;
			target_q  <= '0;
			applied_q <= '0;
			sync_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_MAX_RTT: max_rtt_q <= cfg_data;
					CFG_SLEW:    slew_q    <= cfg_data[RATE_W-1:0];
					default:     ;
				endcase
			end
			if (cmd.ping) begin
				pend_q <= now_q;
			end
			if (cmd.rtt_calc) begin
				pend_q <= '0;
			end
			if (cmd.push) begin
				if (count_q != CNT_W'(SAMPLE_DEPTH)) begin
					count_q <= count_q + 1'b1;
				end
				oldest_q <= oldest_nxt;
			end
			if (cmd.set_target) begin
				target_q <= best_ofs_q;
				if (!sync_q) begin
					applied_q <= best_ofs_q;
					sync_q    <= 1'b1;
				end
			end
			if (cmd.tick_apply && (diff_q != '0)) begin
				if (mag_q <= (OFS_W + 1)'(step_q)) begin
					applied_q <= target_q;
				end else if (diff_q[OFS_W]) begin
					applied_q <= applied_q - $signed({{(OFS_W - Q_W){1'b0}}, step_q});
				end else begin
					applied_q <= applied_q + $signed({{(OFS_W - Q_W){1'b0}}, step_q});
				end
			end
		end
	end

	// Working and payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			now_q     <= local_time_ms;
			stamp_q   <= server_stamp_ms;
			delta_q   <= tick_delta_us;
			rtt_out_q <= '0;
		end
		if (cmd.rtt_calc) begin
			rtt_q <= now_q - pend_q;
		end
		if (cmd.rtt_report) begin
			rtt_out_q <= (rtt_q > TIME_W'({RTT_W{1'b1}})) ? {RTT_W{1'b1}} : rtt_q[RTT_W-1:0];
		end
		if (cmd.ofs_sum) begin
			sum_q <= {1'b0, stamp_q} + OFS_W'(rtt_q[RTT_W-1:1]);
		end
		if (cmd.push) begin
			ofs_mem_q[slot] <= ofs_sat;
			rtt_mem_q[slot] <= rtt_q[RTT_W-1:0];
			walk_k_q        <= oldest_nxt;
			walk_i_q        <= '0;
		end
		if (cmd.walk) begin
			if (take) begin
				best_ofs_q <= ofs_mem_q[walk_k_q];
				best_rtt_q <= rtt_mem_q[walk_k_q];
			end
			walk_k_q <= inc_idx(walk_k_q);
			walk_i_q <= walk_i_q + 1'b1;
		end
		if (cmd.tick_mul) begin
			prod_q <= PROD_W'(slew_q) * PROD_W'(delta_q);
		end
		if (cmd.tick_recip) begin
			q0_q   <= recip_prod[RECIP_SHIFT +: Q_W];
			diff_q <= (OFS_W + 1)'(target_q) - (OFS_W + 1)'(applied_q);
		end
		if (cmd.tick_rem) begin
			rem_q <= REM_W'({1'b0, prod_q} - q_times);
			mag_q <= diff_q[OFS_W] ? (OFS_W + 1)'(-diff_q) : (OFS_W + 1)'(diff_q);
		end
		if (cmd.tick_corr) begin
			step_q <= (q_fix == '0) ? Q_W'(1) : q_fix;
		end
		if (cmd.load_out) begin
			out_status_q  <= cmd.status;
			out_rtt_q     <= rtt_out_q;
			out_target_q  <= target_q;
			out_applied_q <= applied_q;
			out_synced_q  <= sync_q;
		end
	end

	assign out_status     = out_status_q;
	assign out_rtt_ms     = out_rtt_q;
	assign out_target_ms  = out_target_q;
	assign out_applied_ms = out_applied_q;
	assign out_synced     = out_synced_q;

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for clock_offset_tracker: directed rows, then random
// ping/echo/tick traffic over several register settings. Depends on cot_pkg and the RTL.
module testbench;
	import cot_pkg::*;

	// The operation field has one code that the block does not use. It must be
	// ignored, but it still returns a result transaction.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;
	localparam longint OFS_HI = 64'sd281474976710655;
	localparam longint OFS_LO = -64'sd281474976710656;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_PER_PHASE = 225;
	localparam int PHASE_COUNT = 5;

	// One result transaction, field by field.
	typedef struct packed {
		status_t            status;
		logic [15:0]        rtt;
		logic signed [48:0] target;
		logic signed [48:0] applied;
		logic               synced;
	} offset_report_t;

	// One directed row. Where typed_want is set, want is the expected result and
	// the predictor only keeps its state in step; elsewhere the predictor decides.
	typedef struct packed {
		logic [1:0]     op;
		logic [47:0]    now;
		logic [47:0]    stamp;
		logic [23:0]    delta;
		logic           typed_want;
		offset_report_t want;
	} stim_row_t;

	localparam offset_report_t IDLE_REPORT = '{STAT_OK, 16'd0, 49'sd0, 49'sd0, 1'b0};
	localparam offset_report_t ORPHAN_REPORT = '{STAT_NO_PING, 16'd0, 49'sd0, 49'sd0, 1'b0};
	localparam offset_report_t PREDICT = '0;

	localparam int ROW_COUNT = 25;
	localparam stim_row_t DIRECTED_ROWS [ROW_COUNT] = '{
		// Before any sync: an echo with no ping, a tick, the unused code.
		'{OP_ECHO, 48'd100, 48'd5, 24'd0, 1'b1, ORPHAN_REPORT},
		'{OP_TICK, 48'd0, 48'd0, 24'd1000000, 1'b1, IDLE_REPORT},
		'{OP_UNUSED, TIME_MAX, TIME_MAX, 24'hFF_FFFF, 1'b1, IDLE_REPORT},
		// A ping at time zero leaves nothing pending.
		'{OP_PING, 48'd0, 48'd0, 24'd0, 1'b1, IDLE_REPORT},
		'{OP_ECHO, 48'd50, 48'd7, 24'd0, 1'b1, ORPHAN_REPORT},
		// An echo that claims to arrive before its ping went out.
		'{OP_PING, 48'd1000, 48'd0, 24'd0, 1'b1, IDLE_REPORT},
		'{OP_ECHO, 48'd999, 48'd0, 24'd0, 1'b1, ORPHAN_REPORT},
		// A round trip of 2000 ms is over the reset limit: dropped, ping cleared.
		'{OP_ECHO, 48'd3000, 48'd9, 24'd0, 1'b1,
			'{STAT_DROPPED, 16'd2000, 49'sd0, 49'sd0, 1'b0}},
		'{OP_ECHO, 48'd3001, 48'd9, 24'd0, 1'b1, ORPHAN_REPORT},
		// First accepted sample: 50000 + 50 - 10100, applied at once.
		'{OP_PING, 48'd10000, 48'd0, 24'd0, 1'b1, IDLE_REPORT},
		'{OP_ECHO, 48'd10100, 48'd50000, 24'd0, 1'b1,
			'{STAT_ACCEPTED, 16'd100, 49'sd39950, 49'sd39950, 1'b1}},
		// A shorter trip takes over the target; ticks then slew toward it.
		'{OP_PING, 48'd20000, 48'd0, 24'd0, 1'b0, PREDICT},
		'{OP_ECHO, 48'd20040, 48'd20000, 24'd0, 1'b0, PREDICT},
		'{OP_TICK, 48'd0, 48'd0, 24'd1000000, 1'b0, PREDICT},
		'{OP_TICK, 48'd0, 48'd0, 24'd0, 1'b0, PREDICT},
		'{OP_TICK, 48'd0, 48'd0, 24'hFF_FFFF, 1'b0, PREDICT},
		// Most negative offset the fields allow: receive at the top of the clock.
		'{OP_PING, 48'hFFFF_FFFF_FFF5, 48'd0, 24'd0, 1'b0, PREDICT},
		'{OP_ECHO, TIME_MAX, 48'd0, 24'd0, 1'b0, PREDICT},
		// Most positive offset with the same trip: the older sample keeps the target.
		'{OP_PING, 48'd1, 48'd0, 24'd0, 1'b0, PREDICT},
		'{OP_ECHO, 48'd11, TIME_MAX, 24'd0, 1'b0, PREDICT},
		// A trip exactly at the limit is still accepted.
		'{OP_PING, 48'd5000, 48'd0, 24'd0, 1'b0, PREDICT},
		'{OP_ECHO, 48'd6000, 48'd6000, 24'd0, 1'b0, PREDICT},
		// A trip beyond 16 bits reports a saturated rtt.
		'{OP_PING, 48'd5, 48'd0, 24'd0, 1'b0, PREDICT},
		'{OP_ECHO, 48'd100005, 48'd0, 24'd0, 1'b0, PREDICT},
		'{OP_TICK, 48'd0, 48'd0, 24'h80_0000, 1'b0, PREDICT}
	};

	// Register settings of the random phases. The last phase draws its own.
	localparam logic [15:0] PHASE_MAX_RTT [PHASE_COUNT] = '{16'd65535, 16'd0, 16'd200,
		16'd5000, 16'd0};
	localparam logic [9:0] PHASE_SLEW [PHASE_COUNT] = '{10'd1023, 10'd0, 10'd1, 10'd512,
		10'd0};

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [0:0]   cfg_index;
	logic [15:0]  cfg_data;
	logic         s_tvalid;
	logic         s_tready;
	logic [119:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [119:0] m_tdata;
	logic [1:0]   m_tuser;

	clock_offset_tracker u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	// Predictor state: our own copy of the registers and of the sample window.
	logic [15:0]        max_rtt_cfg;
	logic [9:0]         slew_cfg;
	logic [47:0]        pending_ping_ms;
	logic signed [48:0] kept_ofs [SAMPLE_DEPTH];
	logic [15:0]        kept_rtt [SAMPLE_DEPTH];
	int                 kept_count;
	int                 oldest_slot;
	longint             target_ms;
	longint             applied_ms;
	bit                 is_synced;

	offset_report_t expected_reports [$];

	bit gaps_enabled;
	int mismatch_count;
	int results_checked;
	int items_sent;
	int samples_accepted;
	int echoes_dropped;
	int echoes_orphaned;
	int ticks_sent;
	int cycle_count;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Works out the result of one accepted input transaction and moves the
	// predictor state along, exactly as the block is meant to.
	function automatic offset_report_t advance_tracker(input logic [1:0] op,
			input logic [47:0] now, input logic [47:0] stamp, input logic [23:0] delta);
		offset_report_t rep;
		longint unsigned trip;
		longint unsigned step_u;
		longint ofs;
		longint diff;
		longint step;
		longint mag;
		int slot;
		int k;
		logic [15:0] best_rtt;
		rep = IDLE_REPORT;
		if (op == OP_PING) begin
			pending_ping_ms = now;
		end else if (op == OP_ECHO) begin
			if (pending_ping_ms == 48'd0 || now < pending_ping_ms) begin
				rep.status = STAT_NO_PING;
			end else begin
				trip = 64'(now) - 64'(pending_ping_ms);
				rep.rtt = (trip > 64'd65535) ? 16'hFFFF : trip[15:0];
				pending_ping_ms = 48'd0;
				if (trip > 64'(max_rtt_cfg)) begin
					rep.status = STAT_DROPPED;
				end else begin
					ofs = longint'(64'(stamp)) + longint'(trip >> 1) - longint'(64'(now));
					if (ofs > OFS_HI) ofs = OFS_HI;
					if (ofs < OFS_LO) ofs = OFS_LO;
					// Fill the window first; once full, overwrite the oldest sample.
					if (kept_count < SAMPLE_DEPTH) begin
						slot = (oldest_slot + kept_count) % SAMPLE_DEPTH;
						kept_count++;
					end else begin
						slot = oldest_slot;
						oldest_slot = (oldest_slot + 1) % SAMPLE_DEPTH;
					end
					kept_ofs[slot] = ofs[48:0];
					kept_rtt[slot] = trip[15:0];
					// Least rtt wins; strict compare so that the oldest wins a tie.
					target_ms = kept_ofs[oldest_slot];
					best_rtt = kept_rtt[oldest_slot];
					for (int i = 1; i < kept_count; i++) begin
						k = (oldest_slot + i) % SAMPLE_DEPTH;
						if (kept_rtt[k] < best_rtt) begin
							best_rtt = kept_rtt[k];
							target_ms = kept_ofs[k];
						end
					end
					if (!is_synced) begin
						applied_ms = target_ms;
						is_synced = 1'b1;
					end
					rep.status = STAT_ACCEPTED;
				end
			end
		end else if (op == OP_TICK && is_synced) begin
			diff = target_ms - applied_ms;
			if (diff != 0) begin
				step_u = (64'(slew_cfg) * 64'(delta)) / 64'd1000000;
				step = longint'(step_u);
				if (step < 1) step = 1;
				mag = (diff < 0) ? -diff : diff;
				if (mag <= step) applied_ms = target_ms;
				else applied_ms = applied_ms + ((diff > 0) ? step : -step);
			end
		end
		rep.target = target_ms[48:0];
		rep.applied = applied_ms[48:0];
		rep.synced = is_synced;
		return rep;
	endfunction

	function automatic logic [47:0] rand48();
		return 48'({$urandom(), $urandom()});
	endfunction

	// Offers one input transaction, called and returning at a falling edge.
	// Random idle cycles come first while gaps are enabled.
	task automatic send_item(input logic [1:0] op, input logic [47:0] now,
			input logic [47:0] stamp, input logic [23:0] delta, input bit typed_want,
			input offset_report_t want);
		offset_report_t predicted;
		while (gaps_enabled && $urandom_range(99) < 17) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {delta, stamp, now};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predicted = advance_tracker(op, now, stamp, delta);
		expected_reports.push_back(typed_want ? want : predicted);
		if (op != OP_UNUSED) items_sent++;
		if (op == OP_TICK) ticks_sent++;
		case (predicted.status)
			STAT_ACCEPTED: samples_accepted++;
			STAT_DROPPED:  echoes_dropped++;
			STAT_NO_PING:  echoes_orphaned++;
			default: ;
		endcase
		@(negedge clk);
	endtask

	// Stops offering input and waits until every expected result is back.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_reports.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	// Writes both registers on consecutive cycles while the block is idle.
	// Bits above the slew register's width carry junk that must be ignored.
	task automatic apply_settings(input logic [15:0] max_rtt, input logic [9:0] slew);
		cfg_we <= 1'b1;
		cfg_index <= CFG_MAX_RTT;
		cfg_data <= max_rtt;
		@(negedge clk);
		cfg_index <= CFG_SLEW;
		cfg_data <= {6'($urandom()), slew};
		@(negedge clk);
		cfg_we <= 1'b0;
		max_rtt_cfg = max_rtt;
		slew_cfg = slew;
	endtask

	// Random traffic: mostly complete ping/echo exchanges with random content,
	// ticks of all sizes, and some noise (stray echoes, stray pings, echoes
	// that arrive before their ping, the unused code).
	task automatic run_random(input int quota);
		int sent;
		int pick;
		int unsigned cap;
		longint unsigned trip;
		longint unsigned t_ping;
		longint unsigned t_echo;
		longint stamp_l;
		logic [47:0] junk_a;
		logic [47:0] junk_b;
		logic [23:0] junk_d;
		logic [23:0] delta;
		sent = 0;
		while (sent < quota) begin
			pick = $urandom_range(99);
			junk_a = rand48();
			junk_b = rand48();
			junk_d = 24'($urandom());
			if (pick < 55) begin
				cap = (max_rtt_cfg < 16'd300) ? max_rtt_cfg : 300;
				case ($urandom_range(9))
					0, 1, 2, 3, 4, 5: trip = $urandom_range(cap);
					6, 7: trip = max_rtt_cfg - $urandom_range((max_rtt_cfg < 16'd3) ?
						max_rtt_cfg : 3);
					8: trip = 64'(max_rtt_cfg) + 1 + $urandom_range(50);
					default: trip = $urandom_range(1 << 20);
				endcase
				t_ping = ($urandom_range(3) == 0) ? 64'($urandom_range(100000)) : rand48();
				if (t_ping + trip > 64'(TIME_MAX)) t_ping = 64'(TIME_MAX) - trip;
				if (t_ping == 0) t_ping = 1;
				t_echo = t_ping + trip;
				send_item(OP_PING, t_ping[47:0], junk_a, junk_d, 1'b0, PREDICT);
				sent++;
				// A tick between ping and echo must not disturb the pending ping.
				if ($urandom_range(4) == 0) begin
					send_item(OP_TICK, junk_b, junk_a, junk_d, 1'b0, PREDICT);
					sent++;
				end
				// Mostly a server clock close to ours, now and then anywhere.
				if ($urandom_range(9) < 7) begin
					stamp_l = longint'(t_echo) + longint'($urandom_range(2000)) - 1000;
					if (stamp_l < 0) stamp_l = 0;
					if (stamp_l > OFS_HI) stamp_l = OFS_HI;
				end else begin
					stamp_l = longint'(64'(rand48()));
				end
				send_item(OP_ECHO, t_echo[47:0], stamp_l[47:0], junk_d, 1'b0, PREDICT);
				sent++;
			end else if (pick < 85) begin
				case ($urandom_range(9))
					0, 1, 2, 3: delta = 24'($urandom_range(2000000));
					4, 5, 6: delta = junk_d;
					default: delta = 24'($urandom_range(50000));
				endcase
				send_item(OP_TICK, junk_a, junk_b, delta, 1'b0, PREDICT);
				sent++;
			end else begin
				case ($urandom_range(3))
					0: send_item(OP_UNUSED, junk_a, junk_b, junk_d, 1'b0, PREDICT);
					1: begin
						send_item(OP_ECHO, junk_a, junk_b, junk_d, 1'b0, PREDICT);
						sent++;
					end
					2: begin
						send_item(OP_PING, ($urandom_range(2) == 0) ? 48'd0 : junk_a,
							junk_b, junk_d, 1'b0, PREDICT);
						sent++;
					end
					default: begin
						t_ping = 64'(junk_a | 48'd2);
						t_echo = t_ping - 1 - $urandom_range(
							(t_ping - 1 < 64'd1000) ? 32'(t_ping - 1) : 1000);
						send_item(OP_PING, t_ping[47:0], junk_b, junk_d, 1'b0, PREDICT);
						send_item(OP_ECHO, t_echo[47:0], junk_b, junk_d, 1'b0, PREDICT);
						sent += 2;
					end
				endcase
			end
		end
	endtask

	task automatic flag_mismatch(input string field, input longint want_v,
			input longint got_v);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("[%0t] mismatch in %s: expected %0d, got %0d", $realtime, field,
				want_v, got_v);
	endtask

	// Receiver side stalls at random while gaps are enabled.
	always @(negedge clk) begin
		m_tready <= !gaps_enabled || ($urandom_range(99) >= 17);
	end

	// Every result transaction is compared with the oldest expectation.
	always @(posedge clk) begin : result_check
		offset_report_t want;
		offset_report_t seen;
		if (arst_n && m_tvalid && m_tready) begin
			seen.status = status_t'(m_tuser);
			seen.rtt = m_tdata[15:0];
			seen.target = m_tdata[64:16];
			seen.applied = m_tdata[113:65];
			seen.synced = m_tdata[114];
			if (expected_reports.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("[%0t] result transaction with nothing expected", $realtime);
			end else begin
				want = expected_reports.pop_front();
				results_checked++;
				if (seen.status !== want.status)
					flag_mismatch("status", longint'(want.status), longint'(seen.status));
				if (seen.rtt !== want.rtt)
					flag_mismatch("rtt_ms", longint'(want.rtt), longint'(seen.rtt));
				if (seen.target !== want.target)
					flag_mismatch("target_offset_ms", longint'(want.target),
						longint'(seen.target));
				if (seen.applied !== want.applied)
					flag_mismatch("applied_offset_ms", longint'(want.applied),
						longint'(seen.applied));
				if (seen.synced !== want.synced)
					flag_mismatch("synced", longint'(want.synced), longint'(seen.synced));
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Run stopped after %0d cycles with %0d results outstanding",
				cycle_count, expected_reports.size());
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_MAX_RTT;
		cfg_data = 16'd0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 2'd0;
		m_tready = 1'b0;
		gaps_enabled = 1'b1;
		mismatch_count = 0;
		results_checked = 0;
		items_sent = 0;
		samples_accepted = 0;
		echoes_dropped = 0;
		echoes_orphaned = 0;
		ticks_sent = 0;
		cycle_count = 0;
		// Predictor starts from the reset state of the block.
		max_rtt_cfg = MAX_RTT_RST;
		slew_cfg = SLEW_RST;
		pending_ping_ms = 48'd0;
		kept_count = 0;
		oldest_slot = 0;
		target_ms = 0;
		applied_ms = 0;
		is_synced = 1'b0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed rows run with the reset values of both registers.
		for (int r = 0; r < ROW_COUNT; r++)
			send_item(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].now, DIRECTED_ROWS[r].stamp,
				DIRECTED_ROWS[r].delta, DIRECTED_ROWS[r].typed_want, DIRECTED_ROWS[r].want);

		// Random phases, each under its own register setting. The third phase
		// runs without any idle cycles on either side.
		for (int p = 0; p < PHASE_COUNT; p++) begin
			drain_results();
			gaps_enabled = (p != 2);
			if (p == PHASE_COUNT - 1)
				apply_settings(16'($urandom_range(3000)), 10'($urandom()));
			else
				apply_settings(PHASE_MAX_RTT[p], PHASE_SLEW[p]);
			run_random(RANDOM_PER_PHASE);
		end

		drain_results();
		// Allow time for any stray result transaction to show up.
		repeat (40) @(posedge clk);

		$display("Sent %0d input transactions: %0d ticks, %0d samples accepted, %0d echoes",
			items_sent, ticks_sent, samples_accepted, echoes_dropped);
		$display("dropped as too long, %0d echoes without a usable ping; %0d results checked",
			echoes_orphaned, results_checked);
		if (mismatch_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
